// ===== sv/thp_sensor_compensation_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sensor compensation block
// Concurrent check wrappers that can be compiled out as one group.
// ----------------------------------------------------------------------------
`ifndef THP_SENSOR_COMPENSATION_ASSERT_SVH
`define THP_SENSOR_COMPENSATION_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Check that is switched off while reset is high.
`define THP_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("thp: assertion failed");
// Check that also holds while reset is high.
`define THP_ASSERT_NR(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("thp: assertion failed");
`else
`define THP_ASSERT(lbl, clk, rst, prop)
`define THP_ASSERT_NR(lbl, clk, prop)
`endif
`endif

// ===== sv/thp_pkg.sv =====
// ----------------------------------------------------------------------------
// thp_pkg
// Shared types and constants of the sensor compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package thp_pkg;

   // Width of the pressure divider datapath.
   localparam int DIV_W = 64;

   // Register index of the calibration registers.
   typedef enum logic [2:0] {
      CSR_TEMP_TRIM      = 3'd0,
      CSR_PRESS_TRIM_A   = 3'd1,
      CSR_PRESS_TRIM_B   = 3'd2,
      CSR_PRESS_HUM_TRIM = 3'd3,
      CSR_HUM_TRIM_B     = 3'd4
   } thp_csr_type;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 64;

   // Input word: one raw sample triple.
   typedef struct packed {
      logic [19:0] raw_pressure;
      logic [19:0] raw_temperature;
      logic [15:0] raw_humidity;
   } thp_req_type;

   // Result word.
   typedef struct packed {
      logic signed [18:0] temperature_centi;
      logic [31:0]        pressure_q24_8;
      logic [16:0]        humidity_q22_10;
      logic               pressure_invalid;
   } thp_rsp_type;

   // Side data that rides along with the divider.
   typedef struct packed {
      logic [18:0] temp;
      logic [16:0] hum;
      logic        inv;
   } thp_pay_type;

   localparam int PAY_W = $bits(thp_pay_type);

   // Formula constants.
   localparam logic signed [32:0] PRESS_T_OFFSET = 33'sd128000;
   localparam logic signed [31:0] HUM_T_OFFSET   = 32'sd76800;
   localparam logic [20:0]        PRESS_FULL     = 21'd1048576;
   localparam logic signed [12:0] PRESS_SCALE    = 13'sd3125;
   localparam logic signed [31:0] HUM_CLAMP      = 32'sd419430400;
   localparam logic signed [31:0] HUM_RND_A      = 32'sd16384;
   localparam logic signed [31:0] HUM_G3_BIAS    = 32'sd32768;
   localparam logic signed [31:0] HUM_RHS_BIAS   = 32'sd2097152;
   localparam logic signed [31:0] HUM_RND_B      = 32'sd8192;

endpackage

`default_nettype wire

// ===== sv/thp_sdiv_pipe.sv =====
// ----------------------------------------------------------------------------
// thp_sdiv_pipe
// Pipelined restoring divider on magnitudes, one quotient bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module thp_sdiv_pipe #(
   parameter int DIV_W = thp_pkg::DIV_W,
   parameter int PAY_W = thp_pkg::PAY_W
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             adv,
   input  wire logic             in_valid,
   input  wire logic [DIV_W-1:0] in_num,
   input  wire logic [DIV_W-1:0] in_den,
   input  wire logic             in_neg,
   input  wire logic [PAY_W-1:0] in_pay,
   output logic                  out_valid,
   output logic [DIV_W-1:0]      out_quo,
   output logic                  out_neg,
   output logic [PAY_W-1:0]      out_pay
);

   logic [DIV_W-1:0] rem_ff [DIV_W];
   logic [DIV_W-1:0] num_ff [DIV_W];
   logic [DIV_W-1:0] den_ff [DIV_W];
   logic [PAY_W-1:0] pay_ff [DIV_W];
   logic [DIV_W-1:0] neg_ff;
   logic [DIV_W-1:0] vld_ff;

   genvar k;
   for (k = 0; k < DIV_W; k++) begin : g_step
      logic [DIV_W-1:0] rem_prev;
      logic [DIV_W-1:0] num_prev;
      logic [DIV_W-1:0] den_prev;
      logic [PAY_W-1:0] pay_prev;
      logic             neg_prev;
      logic [DIV_W:0]   shifted;
      logic [DIV_W:0]   trial;
      logic             take;

      if (k == 0) begin : g_first
         assign rem_prev = '0;
         assign num_prev = in_num;
         assign den_prev = in_den;
         assign pay_prev = in_pay;
         assign neg_prev = in_neg;
      end else begin : g_next
         assign rem_prev = rem_ff[k-1];
         assign num_prev = num_ff[k-1];
         assign den_prev = den_ff[k-1];
         assign pay_prev = pay_ff[k-1];
         assign neg_prev = neg_ff[k-1];
      end

      // Bring down the next dividend bit and try the subtraction.
      assign shifted = {rem_prev, num_prev[DIV_W-1]};
      assign trial   = shifted - {1'b0, den_prev};
      assign take    = ~trial[DIV_W];

      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[k] <= take ? trial[DIV_W-1:0] : shifted[DIV_W-1:0];
            num_ff[k] <= {num_prev[DIV_W-2:0], take};
            den_ff[k] <= den_prev;
            pay_ff[k] <= pay_prev;
            neg_ff[k] <= neg_prev;
         end
      end
   end

   // Valid bits travel with the data.
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[DIV_W-2:0], in_valid};
      end
   end

   assign out_valid = vld_ff[DIV_W-1];
   assign out_quo   = num_ff[DIV_W-1];
   assign out_neg   = neg_ff[DIV_W-1];
   assign out_pay   = pay_ff[DIV_W-1];

endmodule

`default_nettype wire

// ===== sv/thp_sensor_compensation.sv =====
// Throughput: one word per cycle; the whole pipeline advances together and
// holds while a finished result is stalled on the rsp port.
// The 64-stage pressure divider sets most of the latency.
// Reset: synchronous, active high; clears valid bits and calibration to zero.
// ----------------------------------------------------------------------------
// thp_sensor_compensation
// Integer temperature, pressure and humidity compensation, fully pipelined.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thp_sensor_compensation_assert.svh"

module thp_sensor_compensation (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire thp_pkg::thp_req_type              req_data,
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output thp_pkg::thp_rsp_type                   rsp_data,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [thp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [thp_pkg::CSR_DATA_W-1:0]    csr_data
);

   localparam int FRONT = 15;

   typedef struct packed {
      logic [63:0] num;
      logic [63:0] den;
      logic        neg;
      logic        inv;
   } div_type;

   // ------------------------------------------------------------------
   // Calibration registers
   // ------------------------------------------------------------------
   logic [47:0] temp_trim_ff;
   logic [63:0] press_trim_a_ff;
   logic [63:0] press_trim_b_ff;
   logic [55:0] press_hum_trim_ff;
   logic [23:0] hum_trim_b_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         temp_trim_ff      <= '0;
         press_trim_a_ff   <= '0;
         press_trim_b_ff   <= '0;
         press_hum_trim_ff <= '0;
         hum_trim_b_ff     <= '0;
      end else if (csr_valid && csr_ready) begin
         case (thp_pkg::thp_csr_type'(csr_index))
            thp_pkg::CSR_TEMP_TRIM:      temp_trim_ff      <= csr_data[47:0];
            thp_pkg::CSR_PRESS_TRIM_A:   press_trim_a_ff   <= csr_data;
            thp_pkg::CSR_PRESS_TRIM_B:   press_trim_b_ff   <= csr_data;
            thp_pkg::CSR_PRESS_HUM_TRIM: press_hum_trim_ff <= csr_data[55:0];
            thp_pkg::CSR_HUM_TRIM_B:     hum_trim_b_ff     <= csr_data[23:0];
            default: ;
         endcase
      end
   end

   // Unpacked coefficients.
   logic [15:0]        t1;
   logic signed [15:0] t2, t3;
   logic [15:0]        p1;
   logic signed [15:0] p2, p3, p4, p5, p6, p7, p8, p9;
   logic [7:0]         h1, h3;
   logic signed [15:0] h2;
   logic signed [7:0]  h6;
   logic signed [11:0] h5;

   assign t1 = temp_trim_ff[15:0];
   assign t2 = temp_trim_ff[31:16];
   assign t3 = temp_trim_ff[47:32];
   assign p1 = press_trim_a_ff[15:0];
   assign p2 = press_trim_a_ff[31:16];
   assign p3 = press_trim_a_ff[47:32];
   assign p4 = press_trim_a_ff[63:48];
   assign p5 = press_trim_b_ff[15:0];
   assign p6 = press_trim_b_ff[31:16];
   assign p7 = press_trim_b_ff[47:32];
   assign p8 = press_trim_b_ff[63:48];
   assign p9 = press_hum_trim_ff[15:0];
   assign h1 = press_hum_trim_ff[23:16];
   assign h2 = press_hum_trim_ff[39:24];
   assign h3 = press_hum_trim_ff[47:40];
   assign h6 = press_hum_trim_ff[55:48];
   assign h5 = hum_trim_b_ff[23:12];

   // ------------------------------------------------------------------
   // Flow control: every stage moves when the result register is free.
   // ------------------------------------------------------------------
   logic adv;
   logic rsp_valid_ff;

   assign adv       = ~rsp_valid_ff | ~rsp_stall;
   assign req_stall = ~adv;

   logic [FRONT:1] vld_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[FRONT-1:1], req_valid};
      end
   end

   // ------------------------------------------------------------------
   // Front datapath signals
   // ------------------------------------------------------------------
   logic signed [17:0] s1_a_in, s1_a_ff;
   logic signed [16:0] s1_d_in, s1_d_ff;
   logic [19:0]        rp_ff [1:8];
   logic [15:0]        rh_ff [1:6];

   logic signed [33:0] prod_at, prod_dd;
   logic signed [31:0] s2_at_ff, s2_dd_ff;

   logic signed [31:0] dd_shw;
   logic signed [19:0] dd_sh;
   logic signed [35:0] prod_ddt;
   logic signed [31:0] s3_v1_ff, s3_ddt_ff;

   logic signed [31:0] s4_tf_in, s4_tf_ff;

   logic signed [31:0] t5;
   logic signed [31:0] temp_full;
   logic signed [32:0] s5_w1_in, s5_w1_ff;
   logic signed [31:0] s5_hx_in, s5_hx_ff;
   logic [18:0]        tmp_ff [5:15];

   logic signed [65:0] prod_w1sq;
   logic signed [48:0] prod_w1p5, prod_w1p2;
   logic signed [43:0] prod_h5x;
   logic signed [39:0] prod_xh6;
   logic signed [40:0] prod_xh3;
   logic signed [63:0] s6_w1sq_ff;
   logic signed [48:0] s6_w1p5_ff, s6_w1p2_ff;
   logic signed [31:0] s6_h5x_ff, s6_xh6_ff, s6_xh3_ff;

   logic signed [79:0] prod_w2a, prod_w1sqp3;
   logic signed [31:0] lhs_sum;
   logic signed [63:0] s7_w2a_ff, s7_w1sqp3_ff;
   logic signed [48:0] s7_w1p5_ff, s7_w1p2_ff;
   logic signed [31:0] s7_g6_ff, s7_g3_ff;
   logic signed [31:0] lhs_ff [7:11];

   logic signed [63:0] w1p5_x, w1p2_x, p4_x;
   logic signed [63:0] prod_g63;
   logic signed [63:0] s8_w2_ff, s8_w1b_ff;
   logic signed [31:0] s8_g63_ff;

   logic signed [63:0] w1b_off;
   logic signed [80:0] prod_den;
   logic [20:0]        pp;
   logic signed [63:0] num_pre;
   logic signed [76:0] prod_num;
   logic signed [63:0] s9_prod_ff, s9_num_ff;
   logic signed [31:0] s9_th_ff;

   logic signed [63:0] den_s;
   div_type            div_in;
   div_type            div_ff [10:15];
   logic signed [47:0] prod_th2;
   logic signed [31:0] s10_th2_ff;

   logic signed [31:0] s11_rhs_ff;

   logic signed [63:0] prod_lr;
   logic signed [31:0] s12_lr_ff;

   logic signed [31:0] hs;
   logic signed [63:0] prod_hs2;
   logic signed [31:0] s13_hs2_ff, s13_lr_ff;

   logic signed [31:0] hs2_sh;
   logic signed [40:0] prod_hsh1;
   logic signed [31:0] s14_hsh1_ff, s14_lr_ff;

   logic signed [31:0] hum_raw;
   logic signed [31:0] hum_clamped;
   logic [16:0]        s15_hum_ff;

   // Stage 1: temperature differences from the raw reading.
   always_comb begin
      s1_a_in = $signed({1'b0, req_data.raw_temperature[19:3]})
              - $signed({1'b0, t1, 1'b0});
      s1_d_in = $signed({1'b0, req_data.raw_temperature[19:4]})
              - $signed({1'b0, t1});
   end

   // Stage 2: first temperature products.
   assign prod_at = s1_a_ff * t2;
   assign prod_dd = s1_d_ff * s1_d_ff;

   // Stage 3: second temperature product.
   assign dd_shw   = s2_dd_ff >>> 12;
   assign dd_sh    = dd_shw[19:0];
   assign prod_ddt = dd_sh * t3;

   // Stage 4: fine temperature.
   assign s4_tf_in = s3_v1_ff + (s3_ddt_ff >>> 14);

   // Stage 5: temperature result and offsets for the other two paths.
   always_comb begin
      t5        = (s4_tf_ff <<< 2) + s4_tf_ff + 32'sd128;
      temp_full = t5 >>> 8;
      s5_w1_in  = $signed({s4_tf_ff[31], s4_tf_ff}) - thp_pkg::PRESS_T_OFFSET;
      s5_hx_in  = s4_tf_ff - thp_pkg::HUM_T_OFFSET;
   end

   // Stage 6: first pressure and humidity products.
   assign prod_w1sq = s5_w1_ff * s5_w1_ff;
   assign prod_w1p5 = s5_w1_ff * p5;
   assign prod_w1p2 = s5_w1_ff * p2;
   assign prod_h5x  = s5_hx_ff * h5;
   assign prod_xh6  = s5_hx_ff * h6;
   assign prod_xh3  = s5_hx_ff * $signed({1'b0, h3});

   // Stage 7: square terms of pressure, humidity left and right factors.
   assign prod_w2a    = s6_w1sq_ff * p6;
   assign prod_w1sqp3 = s6_w1sq_ff * p3;
   assign lhs_sum     = $signed({2'b00, rh_ff[6], 14'b0})
                      - $signed({hum_trim_b_ff[11:0], 20'b0})
                      - s6_h5x_ff + thp_pkg::HUM_RND_A;

   // Stage 8: pressure sums and a humidity product.
   always_comb begin
      w1p5_x = s7_w1p5_ff;
      w1p2_x = s7_w1p2_ff;
      p4_x   = p4;
   end
   assign prod_g63 = s7_g6_ff * s7_g3_ff;

   // Stage 9: divisor product and scaled dividend.
   always_comb begin
      w1b_off  = s8_w1b_ff + 64'sh0000_8000_0000_0000;
      prod_den = w1b_off * $signed({1'b0, p1});
      pp       = thp_pkg::PRESS_FULL - {1'b0, rp_ff[8]};
      num_pre  = $signed({12'b0, pp, 31'b0}) - s8_w2_ff;
      prod_num = num_pre * thp_pkg::PRESS_SCALE;
   end

   // Stage 10: divider set-up on magnitudes and a humidity product.
   always_comb begin
      den_s      = s9_prod_ff >>> 33;
      div_in.inv = (den_s == 64'sd0);
      div_in.neg = s9_num_ff[63] ^ den_s[63];
      div_in.num = s9_num_ff[63] ? 64'(-s9_num_ff) : s9_num_ff;
      div_in.den = den_s[63] ? 64'(-den_s) : den_s;
   end
   assign prod_th2 = s9_th_ff * h2;

   // Stage 12 to 14: humidity products.
   assign prod_lr   = lhs_ff[11] * s11_rhs_ff;
   assign hs        = s12_lr_ff >>> 15;
   assign prod_hs2  = hs * hs;
   assign hs2_sh    = s13_hs2_ff >>> 7;
   assign prod_hsh1 = hs2_sh * $signed({1'b0, h1});

   // Stage 15: humidity clamp.
   always_comb begin
      hum_raw = s14_lr_ff - (s14_hsh1_ff >>> 4);
      if (hum_raw < 32'sd0) begin
         hum_clamped = 32'sd0;
      end else if (hum_raw > thp_pkg::HUM_CLAMP) begin
         hum_clamped = thp_pkg::HUM_CLAMP;
      end else begin
         hum_clamped = hum_raw;
      end
   end

   // Front pipeline registers.
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_a_ff      <= s1_a_in;
         s1_d_ff      <= s1_d_in;
         rp_ff[1]     <= req_data.raw_pressure;
         rh_ff[1]     <= req_data.raw_humidity;
         for (int i = 2; i <= 8; i++) rp_ff[i] <= rp_ff[i-1];
         for (int i = 2; i <= 6; i++) rh_ff[i] <= rh_ff[i-1];

         s2_at_ff     <= prod_at[31:0];
         s2_dd_ff     <= prod_dd[31:0];

         s3_v1_ff     <= s2_at_ff >>> 11;
         s3_ddt_ff    <= prod_ddt[31:0];

         s4_tf_ff     <= s4_tf_in;

         tmp_ff[5]    <= temp_full[18:0];
         for (int i = 6; i <= 15; i++) tmp_ff[i] <= tmp_ff[i-1];
         s5_w1_ff     <= s5_w1_in;
         s5_hx_ff     <= s5_hx_in;

         s6_w1sq_ff   <= prod_w1sq[63:0];
         s6_w1p5_ff   <= prod_w1p5;
         s6_w1p2_ff   <= prod_w1p2;
         s6_h5x_ff    <= prod_h5x[31:0];
         s6_xh6_ff    <= prod_xh6[31:0];
         s6_xh3_ff    <= prod_xh3[31:0];

         s7_w2a_ff    <= prod_w2a[63:0];
         s7_w1sqp3_ff <= prod_w1sqp3[63:0];
         s7_w1p5_ff   <= s6_w1p5_ff;
         s7_w1p2_ff   <= s6_w1p2_ff;
         lhs_ff[7]    <= lhs_sum >>> 15;
         for (int i = 8; i <= 11; i++) lhs_ff[i] <= lhs_ff[i-1];
         s7_g6_ff     <= s6_xh6_ff >>> 10;
         s7_g3_ff     <= (s6_xh3_ff >>> 11) + thp_pkg::HUM_G3_BIAS;

         s8_w2_ff     <= s7_w2a_ff + (w1p5_x <<< 17) + (p4_x <<< 35);
         s8_w1b_ff    <= (s7_w1sqp3_ff >>> 8) + (w1p2_x <<< 12);
         s8_g63_ff    <= prod_g63[31:0];

         s9_prod_ff   <= prod_den[63:0];
         s9_num_ff    <= prod_num[63:0];
         s9_th_ff     <= (s8_g63_ff >>> 10) + thp_pkg::HUM_RHS_BIAS;

         div_ff[10]   <= div_in;
         for (int i = 11; i <= 15; i++) div_ff[i] <= div_ff[i-1];
         s10_th2_ff   <= prod_th2[31:0];

         s11_rhs_ff   <= (s10_th2_ff + thp_pkg::HUM_RND_B) >>> 14;

         s12_lr_ff    <= prod_lr[31:0];

         s13_hs2_ff   <= prod_hs2[31:0];
         s13_lr_ff    <= s12_lr_ff;

         s14_hsh1_ff  <= prod_hsh1[31:0];
         s14_lr_ff    <= s13_lr_ff;

         s15_hum_ff   <= hum_clamped[28:12];
      end
   end

   // ------------------------------------------------------------------
   // Pressure divider
   // ------------------------------------------------------------------
   thp_pkg::thp_pay_type div_pay_in, div_pay_out;
   logic [thp_pkg::DIV_W-1:0] div_quo;
   logic div_neg, div_valid;

   always_comb begin
      div_pay_in.temp = tmp_ff[15];
      div_pay_in.hum  = s15_hum_ff;
      div_pay_in.inv  = div_ff[15].inv;
   end

   thp_sdiv_pipe #(
      .DIV_W (thp_pkg::DIV_W),
      .PAY_W (thp_pkg::PAY_W)
   ) u_div (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (vld_ff[FRONT]),
      .in_num    (div_ff[15].num),
      .in_den    (div_ff[15].den),
      .in_neg    (div_ff[15].neg),
      .in_pay    (div_pay_in),
      .out_valid (div_valid),
      .out_quo   (div_quo),
      .out_neg   (div_neg),
      .out_pay   (div_pay_out)
   );

   // ------------------------------------------------------------------
   // Pressure back end
   // ------------------------------------------------------------------
   logic [4:1]           pvld_ff;
   thp_pkg::thp_pay_type ppay_ff [1:4];
   logic signed [63:0]   p_in, q_in;
   logic signed [63:0]   pp_ff [1:4];
   logic signed [63:0]   p1_q_ff;
   logic [31:0]          q_lo, q_hi;
   logic [63:0]          prod_ll, prod_lh;
   logic signed [79:0]   prod_p8p;
   logic [63:0]          p2_ll_ff;
   logic [31:0]          p2_lh_ff;
   logic signed [63:0]   p8p_ff [2:4];
   logic signed [63:0]   p3_sq_ff;
   logic signed [79:0]   prod_w1p;
   logic signed [63:0]   p4_w1p_ff;
   logic signed [63:0]   press_sum, press_sh, p7_x;
   logic [31:0]          press_out;
   thp_pkg::thp_rsp_type rsp_in, rsp_data_ff;

   always_comb begin
      p_in = div_neg ? 64'(-$signed(div_quo)) : $signed(div_quo);
      q_in = p_in >>> 13;
   end

   // Low 64 bits of the square taken from 32-bit halves.
   assign q_lo     = p1_q_ff[31:0];
   assign q_hi     = p1_q_ff[63:32];
   assign prod_ll  = q_lo * q_lo;
   assign prod_lh  = q_lo * q_hi;
   assign prod_p8p = pp_ff[1] * p8;
   assign prod_w1p = p3_sq_ff * p9;

   // Final pressure sum and scale.
   always_comb begin
      p7_x      = p7;
      press_sum = pp_ff[4] + (p4_w1p_ff >>> 25) + (p8p_ff[4] >>> 19);
      press_sh  = (press_sum >>> 8) + (p7_x <<< 4);
      press_out = ppay_ff[4].inv ? 32'd0 : press_sh[31:0];
      rsp_in.temperature_centi = ppay_ff[4].temp;
      rsp_in.pressure_q24_8    = press_out;
      rsp_in.humidity_q22_10   = ppay_ff[4].hum;
      rsp_in.pressure_invalid  = ppay_ff[4].inv;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         pp_ff[1]    <= p_in;
         p1_q_ff     <= q_in;
         ppay_ff[1]  <= div_pay_out;
         for (int i = 2; i <= 4; i++) begin
            pp_ff[i]   <= pp_ff[i-1];
            ppay_ff[i] <= ppay_ff[i-1];
         end

         p2_ll_ff    <= prod_ll;
         p2_lh_ff    <= prod_lh[31:0];
         p8p_ff[2]   <= prod_p8p[63:0];
         for (int i = 3; i <= 4; i++) p8p_ff[i] <= p8p_ff[i-1];

         p3_sq_ff    <= $signed(p2_ll_ff + {p2_lh_ff[30:0], 33'b0});

         p4_w1p_ff   <= prod_w1p[63:0];

         rsp_data_ff <= rsp_in;
      end
   end

   // Back-end valid bits and the result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         pvld_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         pvld_ff      <= {pvld_ff[3:1], div_valid};
         rsp_valid_ff <= pvld_ff[4];
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `THP_ASSERT_NR(a_reset_clears_rsp, clock, reset |=> !rsp_valid)
   `THP_ASSERT(a_invalid_zero, clock, reset, rsp_valid && rsp_data.pressure_invalid |-> rsp_data.pressure_q24_8 == 32'd0)
   `THP_ASSERT(a_hum_range, clock, reset, rsp_valid |-> rsp_data.humidity_q22_10 <= 17'd102400)
   `THP_ASSERT(a_held_blocks_input, clock, reset, rsp_valid && rsp_stall |-> req_stall)

endmodule

`default_nettype wire
